// File: rtl/core/ktt_pkg.sv
// Package for the keyed threshold table: sizes, opcodes, sequencer states and record type.
package ktt_pkg;

	localparam int ENTRIES = 32;
	localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CNT_W   = $clog2(ENTRIES + 1);

	localparam int OP_W    = 2;
	localparam int KEY_W   = 16;
	localparam int TEMP_W  = 16;
	localparam int HUMID_W = 14;
	localparam int SOIL_W  = 16;
	localparam int LIGHT_W = 16;

	typedef enum logic [OP_W-1:0] {
		OP_SET    = 2'd0,
		OP_GET    = 2'd1,
		OP_REMOVE = 2'd2,
		OP_CLEAR  = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_ACT,
		ST_FETCH,
		ST_DONE
	} state_t;

	// one stored record, without its key
	typedef struct packed {
		logic        [LIGHT_W-1:0] light_high;
		logic        [LIGHT_W-1:0] light_low;
		logic        [SOIL_W-1:0]  soil_high;
		logic        [SOIL_W-1:0]  soil_low;
		logic        [HUMID_W-1:0] humid_high;
		logic        [HUMID_W-1:0] humid_low;
		logic signed [TEMP_W-1:0]  temp_high;
		logic signed [TEMP_W-1:0]  temp_low;
	} rec_t;

endpackage

// File: rtl/core/ktt_req_if.sv
// Request channel of the keyed threshold table: valid/ready with opcode, key and thresholds.
interface ktt_req_if;
	import ktt_pkg::*;

	logic                      valid;
	logic                      ready;
	logic        [OP_W-1:0]    opcode;
	logic        [KEY_W-1:0]   key;
	logic signed [TEMP_W-1:0]  temp_low;
	logic signed [TEMP_W-1:0]  temp_high;
	logic        [HUMID_W-1:0] humid_low;
	logic        [HUMID_W-1:0] humid_high;
	logic        [SOIL_W-1:0]  soil_low;
	logic        [SOIL_W-1:0]  soil_high;
	logic        [LIGHT_W-1:0] light_low;
	logic        [LIGHT_W-1:0] light_high;

	modport source (
		output valid, opcode, key, temp_low, temp_high, humid_low, humid_high,
		       soil_low, soil_high, light_low, light_high,
		input  ready
	);

	modport sink (
		input  valid, opcode, key, temp_low, temp_high, humid_low, humid_high,
		       soil_low, soil_high, light_low, light_high,
		output ready
	);

endinterface

// File: rtl/core/ktt_rsp_if.sv
// Response channel of the keyed threshold table: valid/ready with status and fetched record.
interface ktt_rsp_if;
	import ktt_pkg::*;

	logic                      valid;
	logic                      ready;
	logic                      success;
	logic signed [TEMP_W-1:0]  got_temp_low;
	logic signed [TEMP_W-1:0]  got_temp_high;
	logic        [HUMID_W-1:0] got_humid_low;
	logic        [HUMID_W-1:0] got_humid_high;
	logic        [SOIL_W-1:0]  got_soil_low;
	logic        [SOIL_W-1:0]  got_soil_high;
	logic        [LIGHT_W-1:0] got_light_low;
	logic        [LIGHT_W-1:0] got_light_high;

	modport source (
		output valid, success, got_temp_low, got_temp_high, got_humid_low, got_humid_high,
		       got_soil_low, got_soil_high, got_light_low, got_light_high,
		input  ready
	);

	modport sink (
		input  valid, success, got_temp_low, got_temp_high, got_humid_low, got_humid_high,
		       got_soil_low, got_soil_high, got_light_low, got_light_high,
		output ready
	);

endinterface

// File: rtl/core/keyed_threshold_table.sv
// Top level of the keyed threshold table: key/record memories and the search sequencer.
// Flow, accept to response valid: clear goes straight to the done state; set, get and
//   remove scan the key memory one key per cycle up to the first hit, then act, and a
//   get or remove that hits adds a fetch step before done.
// One request is in work at a time; a finished beat sits in the output
//   register, so the next request is taken while the response still waits.
// Reset: arst_n clears the sequencer, the entry count and the response valid;
//   the memories are not cleared, entries at or above the count are never used.
module keyed_threshold_table (
	input  logic      clk,
	input  logic      arst_n,
	ktt_req_if.sink   req,
	ktt_rsp_if.source rsp
);
	import ktt_pkg::*;

	// Storage: one memory for keys, one for records, each one write and one read port,
	// read data registered.
	logic [KEY_W-1:0] key_mem [ENTRIES];
	rec_t             rec_mem [ENTRIES];

	logic [KEY_W-1:0] key_rd_q;
	rec_t             rec_rd_q;
	logic [IDX_W-1:0] key_raddr;
	logic [IDX_W-1:0] rec_raddr;
	logic [IDX_W-1:0] waddr;
	logic [KEY_W-1:0] key_wdata;
	rec_t             rec_wdata;
	logic             mem_we;

	// Request capture (payload, no reset)
	op_t              op_q;
	logic [KEY_W-1:0] key_q;
	rec_t             rec_in_q;

	// Sequencer control
	state_t           state_q, state_d;
	logic [CNT_W-1:0] count_q, count_d;
	logic [CNT_W-1:0] idx_q, idx_d;
	logic             cmp_v_s1, cmp_v_d;
	logic [IDX_W-1:0] cmp_idx_s1;
	logic             found_q, found_d;
	logic [IDX_W-1:0] slot_q, slot_d;
	logic [CNT_W-1:0] last_cnt;
	logic [IDX_W-1:0] last_idx;
	logic             key_hit;
	logic             room;

	// Result staged for the output register
	logic             res_ok_q, res_ok_d;
	rec_t             res_rec_q, res_rec_d;

	// Output register
	logic             rsp_valid_q;
	logic             rsp_ok_q;
	rec_t             rsp_rec_q;
	logic             load_out;
	logic             req_ready;
	logic             req_acc;

	assign req_acc  = req.valid & req_ready;
	assign last_cnt = count_q - CNT_W'(1);
	assign last_idx = last_cnt[IDX_W-1:0];
	assign key_hit  = cmp_v_s1 && (key_rd_q == key_q);
	assign room     = count_q < CNT_W'(ENTRIES);

	// Key port reads the scan index while scanning, otherwise the last entry for a remove.
	assign key_raddr = (state_q == ST_SCAN) ? idx_q[IDX_W-1:0] : last_idx;
	// Record port reads the hit slot for get, the last entry for remove.
	assign rec_raddr = (op_q == OP_GET) ? slot_q : last_idx;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			key_mem[waddr] <= key_wdata;
			rec_mem[waddr] <= rec_wdata;
		end
		key_rd_q <= key_mem[key_raddr];
		rec_rd_q <= rec_mem[rec_raddr];
	end

	// Capture the request beat.
	always_ff @(posedge clk) begin
		if (req_acc) begin
			op_q                <= op_t'(req.opcode);
			key_q               <= req.key;
			rec_in_q.temp_low   <= req.temp_low;
			rec_in_q.temp_high  <= req.temp_high;
			rec_in_q.humid_low  <= req.humid_low;
			rec_in_q.humid_high <= req.humid_high;
			rec_in_q.soil_low   <= req.soil_low;
			rec_in_q.soil_high  <= req.soil_high;
			rec_in_q.light_low  <= req.light_low;
			rec_in_q.light_high <= req.light_high;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			count_q    <= '0;
			idx_q      <= '0;
			cmp_v_s1   <= 1'b0;
			cmp_idx_s1 <= '0;
			found_q    <= 1'b0;
			slot_q     <= '0;
			res_ok_q   <= 1'b0;
		end else begin
			state_q    <= state_d;
			count_q    <= count_d;
			idx_q      <= idx_d;
			cmp_v_s1   <= cmp_v_d;
			cmp_idx_s1 <= idx_q[IDX_W-1:0];
			found_q    <= found_d;
			slot_q     <= slot_d;
			res_ok_q   <= res_ok_d;
		end
	end

	always_ff @(posedge clk) begin
		res_rec_q <= res_rec_d;
	end

	// Sequencer: scan keys in slot order, then act on the first hit or on a miss; clear skips the scan.
	always_comb begin
		state_d   = state_q;
		count_d   = count_q;
		idx_d     = idx_q;
		cmp_v_d   = 1'b0;
		found_d   = found_q;
		slot_d    = slot_q;
		res_ok_d  = res_ok_q;
		res_rec_d = res_rec_q;
		mem_we    = 1'b0;
		waddr     = slot_q;
		key_wdata = key_q;
		rec_wdata = rec_in_q;
		load_out  = 1'b0;
		req_ready = 1'b0;

		unique case (state_q)
			ST_IDLE: begin
				req_ready = 1'b1;
				if (req.valid) begin
					if (op_t'(req.opcode) == OP_CLEAR) begin
						// stored bits stay, the count alone drops them
						count_d   = '0;
						res_ok_d  = 1'b1;
						res_rec_d = '0;
						state_d   = ST_DONE;
					end else begin
						idx_d   = '0;
						found_d = 1'b0;
						state_d = ST_SCAN;
					end
				end
			end
			ST_SCAN: begin
				if (key_hit) begin
					found_d = 1'b1;
					slot_d  = cmp_idx_s1;
					state_d = ST_ACT;
				end else if (idx_q < count_q) begin
					// issue the next key read, compare it in the following cycle
					cmp_v_d = 1'b1;
					idx_d   = idx_q + CNT_W'(1);
				end else begin
					state_d = ST_ACT;
				end
			end
			ST_ACT: begin
				res_rec_d = '0;
				res_ok_d  = 1'b0;
				state_d   = ST_DONE;
				unique case (op_q)
					OP_SET: begin
						if (found_q || room) begin
							mem_we   = 1'b1;
							waddr    = found_q ? slot_q : count_q[IDX_W-1:0];
							res_ok_d = 1'b1;
							if (!found_q) begin
								count_d = count_q + CNT_W'(1);
							end
						end
					end
					OP_GET, OP_REMOVE: begin
						// record read (and last key read for remove) issues this cycle
						if (found_q) begin
							state_d = ST_FETCH;
						end
					end
					OP_CLEAR: begin
						res_ok_d = 1'b1;
					end
				endcase
			end
			ST_FETCH: begin
				res_ok_d = 1'b1;
				state_d  = ST_DONE;
				if (op_q == OP_GET) begin
					res_rec_d = rec_rd_q;
				end else begin
					// move the last entry into the hit slot and shrink
					res_rec_d = '0;
					mem_we    = 1'b1;
					waddr     = slot_q;
					key_wdata = key_rd_q;
					rec_wdata = rec_rd_q;
					count_d   = last_cnt;
				end
			end
			ST_DONE: begin
				// hold until the output register is free
				if (!rsp_valid_q || rsp.ready) begin
					load_out = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Output register: load a finished beat, drop valid once taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (load_out) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			rsp_ok_q  <= res_ok_q;
			rsp_rec_q <= res_rec_q;
		end
	end

	assign req.ready          = req_ready;
	assign rsp.valid          = rsp_valid_q;
	assign rsp.success        = rsp_ok_q;
	assign rsp.got_temp_low   = rsp_rec_q.temp_low;
	assign rsp.got_temp_high  = rsp_rec_q.temp_high;
	assign rsp.got_humid_low  = rsp_rec_q.humid_low;
	assign rsp.got_humid_high = rsp_rec_q.humid_high;
	assign rsp.got_soil_low   = rsp_rec_q.soil_low;
	assign rsp.got_soil_high  = rsp_rec_q.soil_high;
	assign rsp.got_light_low  = rsp_rec_q.light_low;
	assign rsp.got_light_high = rsp_rec_q.light_high;

endmodule

// File: rtl/core/ktt_checker.sv
// Port-level assertions for the keyed threshold table and the bind that attaches them.
module ktt_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              req_valid,
	input logic                              req_ready,
	input logic                              rsp_valid,
	input logic                              rsp_ready,
	input logic                              success,
	input logic signed [ktt_pkg::TEMP_W-1:0] got_temp_low,
	input logic signed [ktt_pkg::TEMP_W-1:0] got_temp_high,
	input logic [ktt_pkg::HUMID_W-1:0]       got_humid_low,
	input logic [ktt_pkg::HUMID_W-1:0]       got_humid_high,
	input logic [ktt_pkg::SOIL_W-1:0]        got_soil_low,
	input logic [ktt_pkg::SOIL_W-1:0]        got_soil_high,
	input logic [ktt_pkg::LIGHT_W-1:0]       got_light_low,
	input logic [ktt_pkg::LIGHT_W-1:0]       got_light_high
);
	import ktt_pkg::*;

	logic       req_acc;
	logic       rsp_acc;
	logic [1:0] pend_q;

	assign req_acc = req_valid & req_ready;
	assign rsp_acc = rsp_valid & rsp_ready;

	// count requests taken whose response beat has not yet been taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else begin
			pend_q <= pend_q + {1'b0, req_acc} - {1'b0, rsp_acc};
		end
	end

	// a response beat holds until taken
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("response valid dropped before ready");

	// a failed operation returns an all-zero record
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !success |-> (got_temp_low == '0) && (got_temp_high == '0) &&
		(got_humid_low == '0) && (got_humid_high == '0) && (got_soil_low == '0) &&
		(got_soil_high == '0) && (got_light_low == '0) && (got_light_high == '0))
		else $error("failed response carries nonzero record");

	// one request in work at a time: ready falls right after a request is taken
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		req_acc |=> !req_ready)
		else $error("request taken while another is in work");

	// no response beat without a request behind it, and at most two outstanding
	a_rsp_owed: assert property (@(posedge clk) disable iff (!arst_n)
		(!rsp_valid || pend_q != 2'd0) && pend_q != 2'd3)
		else $error("response without request, or too many outstanding");

endmodule

bind keyed_threshold_table ktt_checker u_ktt_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.req_valid      (req.valid),
	.req_ready      (req.ready),
	.rsp_valid      (rsp.valid),
	.rsp_ready      (rsp.ready),
	.success        (rsp.success),
	.got_temp_low   (rsp.got_temp_low),
	.got_temp_high  (rsp.got_temp_high),
	.got_humid_low  (rsp.got_humid_low),
	.got_humid_high (rsp.got_humid_high),
	.got_soil_low   (rsp.got_soil_low),
	.got_soil_high  (rsp.got_soil_high),
	.got_light_low  (rsp.got_light_low),
	.got_light_high (rsp.got_light_high)
);

// File: test/tb_keyed_threshold_table.sv
// Self-checking testbench for the keyed threshold table: directed and random command streams.
`timescale 1ns / 100ps

module tb_keyed_threshold_table;
	import ktt_pkg::*;

	// generous cap: ~900 commands at worst-case scan latency plus stalls, several times over
	localparam int CYCLE_LIMIT  = 300000;
	// tail wait after the last response: one full scan of the table plus write-back
	localparam int DRAIN_CYCLES = ENTRIES + 8;
	localparam int MAX_REPORTS  = 40;

	// one command as the host issues it
	typedef struct {
		op_t              opcode;
		logic [KEY_W-1:0] key;
		rec_t             thr;
	} table_cmd_t;

	// one response as the table should return it
	typedef struct {
		logic success;
		rec_t rec;
	} table_result_t;

	logic clk = 1'b0;
	logic arst_n;

	ktt_req_if req ();
	ktt_rsp_if rsp ();

	keyed_threshold_table u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	// Shadow copy of the table contents, updated when a command beat is accepted.
	int               shadow_count = 0;
	logic [KEY_W-1:0] shadow_keys [ENTRIES];
	rec_t             shadow_recs [ENTRIES];

	// Responses still owed by the table, oldest first.
	table_result_t pending_results [$];

	// Keys that random commands draw from, so that lookups actually hit.
	logic [KEY_W-1:0] key_pool [$];

	int err_count    = 0;
	int cycle_count  = 0;
	int result_count = 0;

	// what the run reached, for the closing summary
	int n_stored  = 0;
	int n_full    = 0;
	int n_found   = 0;
	int n_removed = 0;
	int n_missed  = 0;
	int n_cleared = 0;

	// idle controls: random bursts on either side, plus a counted receiver hold-off
	bit src_idle_on  = 1'b1;
	bit sink_idle_on = 1'b1;
	int hold_left    = 0;

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// Prediction
	// ------------------------------------------------------------------

	// Lowest valid slot holding k, or -1 when the key is absent.
	function automatic int find_key(input logic [KEY_W-1:0] k);
		for (int i = 0; i < shadow_count; i++) begin
			if (shadow_keys[i] == k)
				return i;
		end
		return -1;
	endfunction

	// Apply one command to the shadow table and return the response it must produce.
	// Every got_ field stays zero unless a get hits.
	function automatic table_result_t table_apply(input table_cmd_t c);
		table_result_t r;
		int            slot;
		r.success = 1'b0;
		r.rec     = '0;
		slot      = find_key(c.key);
		case (c.opcode)
			OP_SET: begin
				// update in place on a hit, else append if there is room
				if (slot < 0 && shadow_count < ENTRIES) begin
					slot = shadow_count;
					shadow_count++;
				end
				if (slot >= 0) begin
					shadow_keys[slot] = c.key;
					shadow_recs[slot] = c.thr;
					r.success         = 1'b1;
					n_stored++;
				end else begin
					n_full++;
				end
			end
			OP_GET: begin
				if (slot >= 0) begin
					r.success = 1'b1;
					r.rec     = shadow_recs[slot];
					n_found++;
				end else begin
					n_missed++;
				end
			end
			OP_REMOVE: begin
				// the last record moves into the hole, keeping the table packed
				if (slot >= 0) begin
					shadow_keys[slot] = shadow_keys[shadow_count-1];
					shadow_recs[slot] = shadow_recs[shadow_count-1];
					shadow_count--;
					r.success = 1'b1;
					n_removed++;
				end else begin
					n_missed++;
				end
			end
			default: begin
				// clear only drops the count; stored bits stay but are never read
				shadow_count = 0;
				r.success    = 1'b1;
				n_cleared++;
			end
		endcase
		return r;
	endfunction

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------

	// Full-width random thresholds; now and then a humidity above its legal range,
	// which the table must store and return bit for bit.
	function automatic rec_t rand_thresholds();
		rec_t t;
		t.temp_low   = TEMP_W'($urandom);
		t.temp_high  = TEMP_W'($urandom);
		t.soil_low   = SOIL_W'($urandom);
		t.soil_high  = SOIL_W'($urandom);
		t.light_low  = LIGHT_W'($urandom);
		t.light_high = LIGHT_W'($urandom);
		if ($urandom_range(0, 7) == 0) begin
			t.humid_low  = HUMID_W'($urandom);
			t.humid_high = HUMID_W'($urandom);
		end else begin
			t.humid_low  = HUMID_W'($urandom_range(0, 10000));
			t.humid_high = HUMID_W'($urandom_range(0, 10000));
		end
		return t;
	endfunction

	// Weighted opcode choice; whatever is left of 100 goes to clear.
	function automatic op_t pick_op(input int set_w, input int get_w, input int rem_w);
		int r;
		r = $urandom_range(0, 99);
		if (r < set_w)
			return OP_SET;
		if (r < set_w + get_w)
			return OP_GET;
		if (r < set_w + get_w + rem_w)
			return OP_REMOVE;
		return OP_CLEAR;
	endfunction

	// Mostly keys from the pool so that sets, gets and removes hit; a few fully random.
	function automatic logic [KEY_W-1:0] pick_key();
		if ($urandom_range(0, 15) == 0)
			return KEY_W'($urandom);
		return key_pool[$urandom_range(0, key_pool.size() - 1)];
	endfunction

	// A key that is not in the table right now.
	function automatic logic [KEY_W-1:0] fresh_key();
		logic [KEY_W-1:0] k;
		do
			k = KEY_W'($urandom);
		while (find_key(k) >= 0);
		return k;
	endfunction

	// Offer one command beat. Called at a falling edge; returns at the falling edge
	// after acceptance with valid still high, so the next call drives the next beat
	// without a bubble. Callers that stop sending go through wait_drained.
	task automatic send_cmd(input op_t op, input logic [KEY_W-1:0] key, input rec_t thr);
		table_cmd_t c;
		int         gap;
		c.opcode = op;
		c.key    = key;
		c.thr    = thr;
		// now and then a random idle burst before this beat
		if (src_idle_on && $urandom_range(0, 3) == 0) begin
			req.valid <= 1'b0;
			gap = $urandom_range(1, 3);
			repeat (gap) @(negedge clk);
		end
		req.valid      <= 1'b1;
		req.opcode     <= op;
		req.key        <= key;
		req.temp_low   <= thr.temp_low;
		req.temp_high  <= thr.temp_high;
		req.humid_low  <= thr.humid_low;
		req.humid_high <= thr.humid_high;
		req.soil_low   <= thr.soil_low;
		req.soil_high  <= thr.soil_high;
		req.light_low  <= thr.light_low;
		req.light_high <= thr.light_high;
		// hold the beat until the table takes it
		@(posedge clk);
		while (req.ready !== 1'b1)
			@(posedge clk);
		pending_results.push_back(table_apply(c));
		@(negedge clk);
	endtask

	// Drop valid and hold off until every owed response has come back.
	task automatic wait_drained();
		req.valid <= 1'b0;
		@(negedge clk);
		while (pending_results.size() != 0)
			@(negedge clk);
	endtask

	// ------------------------------------------------------------------
	// Checking
	// ------------------------------------------------------------------

	task automatic report_mismatch(input string what);
		err_count++;
		if (err_count <= MAX_REPORTS)
			$display("[%0t] mismatch: %s", $time, what);
	endtask

	task automatic check_field(input string name, input logic [15:0] got,
	                           input logic [15:0] want);
		if (got !== want)
			report_mismatch($sformatf("response %0d %s: got %h, want %h",
			                          result_count, name, got, want));
	endtask

	// Compare every accepted response beat with the oldest owed response.
	always @(posedge clk) begin
		table_result_t want;
		if (arst_n && rsp.valid === 1'b1 && rsp.ready === 1'b1) begin
			result_count++;
			if (pending_results.size() == 0) begin
				report_mismatch("response beat with no command outstanding");
			end else begin
				want = pending_results.pop_front();
				check_field("success",        16'(rsp.success),    16'(want.success));
				check_field("got_temp_low",   rsp.got_temp_low,   want.rec.temp_low);
				check_field("got_temp_high",  rsp.got_temp_high,  want.rec.temp_high);
				check_field("got_humid_low",  16'(rsp.got_humid_low),
				            16'(want.rec.humid_low));
				check_field("got_humid_high", 16'(rsp.got_humid_high),
				            16'(want.rec.humid_high));
				check_field("got_soil_low",   rsp.got_soil_low,   want.rec.soil_low);
				check_field("got_soil_high",  rsp.got_soil_high,  want.rec.soil_high);
				check_field("got_light_low",  rsp.got_light_low,  want.rec.light_low);
				check_field("got_light_high", rsp.got_light_high, want.rec.light_high);
			end
		end
	end

	// Response side: a counted hold-off wins, then random stall bursts, else ready.
	initial begin
		int stall_left;
		stall_left = 0;
		rsp.ready  = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				rsp.ready <= 1'b0;
				hold_left--;
			end else if (stall_left > 0) begin
				rsp.ready <= 1'b0;
				stall_left--;
			end else if (sink_idle_on && $urandom_range(0, 4) == 0) begin
				// stall burst of random length, this one included
				rsp.ready  <= 1'b0;
				stall_left = $urandom_range(0, 2);
			end else begin
				rsp.ready <= 1'b1;
			end
		end
	end

	// Watchdog: a hung handshake ends the run as a failure.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d responses owed",
			         cycle_count, pending_results.size());
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Field extremes, every opcode, misses on an empty table, update in place,
	// remove from first and last slot, clear and reuse of the slots after it.
	task automatic test_directed();
		rec_t lo_rec;
		rec_t hi_rec;
		rec_t mix_rec;
		lo_rec             = '0;
		lo_rec.temp_low    = 16'sh8000;
		lo_rec.temp_high   = 16'sh8000;
		// all ones: humidities land above the legal range and must come back as given
		hi_rec             = '1;
		hi_rec.temp_low    = 16'sh7FFF;
		hi_rec.temp_high   = 16'sh7FFF;
		mix_rec            = rand_thresholds();
		mix_rec.humid_low  = '0;
		mix_rec.humid_high = 14'd10000;

		send_cmd(OP_GET,    16'h0000, hi_rec);   // miss on an empty table, fields ignored
		send_cmd(OP_REMOVE, 16'h0000, '0);       // nothing to remove
		send_cmd(OP_SET,    16'h0000, lo_rec);
		send_cmd(OP_SET,    16'hFFFF, hi_rec);
		send_cmd(OP_GET,    16'h0000, '0);
		send_cmd(OP_GET,    16'hFFFF, lo_rec);
		send_cmd(OP_SET,    16'h0000, mix_rec);  // update in place, count unchanged
		send_cmd(OP_GET,    16'h0000, '0);
		send_cmd(OP_SET,    16'h5A5A, hi_rec);
		send_cmd(OP_REMOVE, 16'h0000, hi_rec);   // first slot: the last record moves in
		send_cmd(OP_GET,    16'h5A5A, '0);
		send_cmd(OP_GET,    16'h0000, '0);
		send_cmd(OP_REMOVE, 16'hFFFF, '0);       // the last slot itself
		send_cmd(OP_GET,    16'hFFFF, '0);
		send_cmd(OP_GET,    16'h5A5A, '0);
		send_cmd(OP_SET,    16'h1234, mix_rec);
		send_cmd(OP_CLEAR,  16'hFFFF, hi_rec);
		send_cmd(OP_GET,    16'h5A5A, '0);       // old bits remain but are invalid
		send_cmd(OP_REMOVE, 16'h1234, '0);
		send_cmd(OP_SET,    16'hA5A5, lo_rec);   // reuse slot zero after the clear
		send_cmd(OP_GET,    16'hA5A5, '0);
		send_cmd(OP_CLEAR,  16'h0000, '0);
		send_cmd(OP_CLEAR,  16'h0000, '0);       // clear of an empty table still succeeds
		send_cmd(OP_REMOVE, 16'hA5A5, '0);
		wait_drained();
	endtask

	// Fill every slot, get a new key rejected, update while full, then free and refill.
	task automatic test_table_full();
		logic [KEY_W-1:0] moved_key;
		send_cmd(OP_CLEAR, KEY_W'($urandom), rand_thresholds());
		for (int i = 0; i < ENTRIES; i++)
			send_cmd(OP_SET, fresh_key(), rand_thresholds());
		send_cmd(OP_SET, fresh_key(), rand_thresholds());             // rejected
		send_cmd(OP_SET, shadow_keys[ENTRIES/2], rand_thresholds());  // update still fits
		send_cmd(OP_GET, shadow_keys[0], '0);
		send_cmd(OP_GET, shadow_keys[ENTRIES-1], '0);
		moved_key = shadow_keys[ENTRIES-1];
		send_cmd(OP_REMOVE, shadow_keys[0], '0);
		send_cmd(OP_GET, moved_key, '0);
		send_cmd(OP_REMOVE, shadow_keys[shadow_count-1], '0);
		send_cmd(OP_SET, fresh_key(), rand_thresholds());
		send_cmd(OP_SET, fresh_key(), rand_thresholds());
		send_cmd(OP_SET, fresh_key(), rand_thresholds());             // rejected, the table is full again
		send_cmd(OP_GET, shadow_keys[shadow_count-1], '0);
		wait_drained();
	endtask

	// Segments of random traffic; each draws keys from a new pool, and the segments cycle
	// through four mixes of idle settings. Set-heavy segments with large pools push the table to full.
	task automatic test_random_mix(input int segments, input int per_seg);
		int pool_n;
		for (int s = 0; s < segments; s++) begin
			src_idle_on  = (s % 4 == 0) || (s % 4 == 1);
			sink_idle_on = (s % 4 == 0) || (s % 4 == 2);
			pool_n       = $urandom_range(8, 64);
			key_pool.delete();
			repeat (pool_n)
				key_pool.push_back(KEY_W'($urandom));
			for (int i = 0; i < per_seg; i++) begin
				if (s % 2 == 0)
					send_cmd(pick_op(55, 25, 18), pick_key(), rand_thresholds());
				else
					send_cmd(pick_op(35, 35, 27), pick_key(), rand_thresholds());
			end
		end
		wait_drained();
	endtask

	// Receiver holds off for a long stretch while commands keep coming, so the output
	// register fills and the table stops taking commands.
	task automatic test_backpressure();
		src_idle_on  = 1'b0;
		sink_idle_on = 1'b0;
		@(posedge clk);
		hold_left = 120;
		@(negedge clk);
		repeat (30)
			send_cmd(pick_op(50, 30, 17), pick_key(), rand_thresholds());
		wait_drained();
	endtask

	// Short bursts, each followed by a pause until the table has answered everything.
	task automatic test_pause();
		src_idle_on  = 1'b1;
		sink_idle_on = 1'b1;
		for (int b = 0; b < 6; b++) begin
			repeat ($urandom_range(3, 12))
				send_cmd(pick_op(45, 30, 22), pick_key(), rand_thresholds());
			wait_drained();
		end
	endtask

	// Closing stretch with no idling on either side.
	task automatic test_full_rate();
		src_idle_on  = 1'b0;
		sink_idle_on = 1'b0;
		repeat (150)
			send_cmd(pick_op(45, 30, 22), pick_key(), rand_thresholds());
		wait_drained();
	endtask

	// ------------------------------------------------------------------
	// Sequence
	// ------------------------------------------------------------------

	initial begin
		// every input known from time zero
		arst_n         = 1'b0;
		req.valid      = 1'b0;
		req.opcode     = OP_SET;
		req.key        = '0;
		req.temp_low   = '0;
		req.temp_high  = '0;
		req.humid_low  = '0;
		req.humid_high = '0;
		req.soil_low   = '0;
		req.soil_high  = '0;
		req.light_low  = '0;
		req.light_high = '0;
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_directed();
		test_table_full();
		test_random_mix(6, 100);
		test_backpressure();
		test_pause();
		test_full_rate();

		// nothing owed; give a stray late beat time to show up
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Covered %0d commands, %0d responses: %0d stores, %0d sets rejected as full,",
		         n_stored + n_full + n_found + n_removed + n_missed + n_cleared,
		         result_count, n_stored, n_full);
		$display("%0d gets that hit, %0d removes, %0d lookups that missed, %0d clears.",
		         n_found, n_removed, n_missed, n_cleared);
		if (err_count == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule

// File: sim.f
rtl/core/ktt_pkg.sv
rtl/core/ktt_req_if.sv
rtl/core/ktt_rsp_if.sv
rtl/core/keyed_threshold_table.sv
rtl/core/ktt_checker.sv
test/tb_keyed_threshold_table.sv
